FILE: sv/pqe_pkg.sv
package pqe_pkg;

  localparam int CoordW = 20;
  localparam int IndexW = 16;
  localparam int ThickW = 12;
  localparam int ColorW = 32;
  localparam int CfgIdxW = 1;
  localparam int DeltaW = CoordW + 1;
  localparam int MagW = CoordW;
  localparam int SqW = 2 * DeltaW;
  localparam int RadW = SqW + 16;
  localparam int RootW = RadW / 2;
  localparam int NumW = MagW + ThickW + 9;
  localparam int DenW = RootW + 1;
  localparam int QuotW = NumW + 1;
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};

  localparam logic [CfgIdxW-1:0] RegColor = 1'b0;
  localparam logic [CfgIdxW-1:0] RegThick = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } in_req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] v0_x;
    logic signed [CoordW-1:0] v0_y;
    logic signed [CoordW-1:0] v1_x;
    logic signed [CoordW-1:0] v1_y;
    logic signed [CoordW-1:0] v2_x;
    logic signed [CoordW-1:0] v2_y;
    logic signed [CoordW-1:0] v3_x;
    logic signed [CoordW-1:0] v3_y;
    logic [ColorW-1:0]        vertex_color;
    logic [IndexW-1:0]        base_index;
    logic                     last_of_run;
  } out_req_t;

  // One segment job handed from the front end to the segment engine.
  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic                     last;
    logic                     clear;
  } seg_job_t;

  function automatic logic signed [CoordW-1:0] sat_coord(
    input logic signed [CoordW+1:0] v
  );
    logic signed [CoordW+1:0] lo;
    logic signed [CoordW+1:0] hi;
    lo = {{2{CoordMin[CoordW-1]}}, CoordMin};
    hi = {2'b00, CoordMax};
    if (v < lo) begin
      return CoordMin;
    end else if (v > hi) begin
      return CoordMax;
    end
    return v[CoordW-1:0];
  endfunction

endpackage

FILE: sv/pqe_front.sv
module pqe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pqe_pkg::in_req_t in_req,
  output logic             in_ready,
  output logic             job_valid,
  output pqe_pkg::seg_job_t job,
  input  logic             job_ready
);

  logic signed [pqe_pkg::CoordW-1:0] first_x;
  logic signed [pqe_pkg::CoordW-1:0] first_y;
  logic signed [pqe_pkg::CoordW-1:0] prev_x;
  logic signed [pqe_pkg::CoordW-1:0] prev_y;
  logic                              started;
  logic                              close_pend;
  logic                              hold_valid;
  pqe_pkg::seg_job_t                 hold;

  // The closing segment is issued as a second job after the last point.
  assign in_ready  = !close_pend && (!hold_valid || job_ready);
  assign job_valid = hold_valid;
  assign job       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      close_pend <= 1'b0;
      hold_valid <= 1'b0;
      first_x    <= '0;
      first_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
    end else begin
      if (hold_valid && job_ready) begin
        hold_valid <= 1'b0;
      end
      if (close_pend && (!hold_valid || job_ready)) begin
        hold       <= '{sx: prev_x, sy: prev_y, ex: first_x, ey: first_y,
                        last: 1'b1, clear: 1'b0};
        hold_valid <= 1'b1;
        close_pend <= 1'b0;
      end else if (in_valid && in_ready) begin
        if (in_req.kind) begin
          hold       <= '{sx: '0, sy: '0, ex: '0, ey: '0, last: 1'b0, clear: 1'b1};
          hold_valid <= 1'b1;
        end else if (!started) begin
          first_x <= in_req.point_x;
          first_y <= in_req.point_y;
          prev_x  <= in_req.point_x;
          prev_y  <= in_req.point_y;
          started <= !in_req.last_point;
        end else begin
          hold       <= '{sx: prev_x, sy: prev_y, ex: in_req.point_x,
                          ey: in_req.point_y, last: 1'b0, clear: 1'b0};
          hold_valid <= 1'b1;
          prev_x     <= in_req.point_x;
          prev_y     <= in_req.point_y;
          if (in_req.last_point) begin
            close_pend <= 1'b1;
            started    <= 1'b0;
          end
        end
      end
    end
  end

endmodule

FILE: sv/pqe_engine.sv
module pqe_engine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_valid,
  input  pqe_pkg::seg_job_t           job,
  output logic                        job_ready,
  input  logic [pqe_pkg::ColorW-1:0]  line_color,
  input  logic [pqe_pkg::ThickW-1:0]  line_thickness,
  output logic                        res_valid,
  output pqe_pkg::out_req_t           res,
  input  logic                        res_ready
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_SQRT = 7'b0000100,
    S_MULX = 7'b0001000,
    S_DIVX = 7'b0010000,
    S_DIVY = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  localparam int CntW = $clog2(pqe_pkg::QuotW + 1);

  state_t                            state;
  pqe_pkg::seg_job_t                 cur;
  logic [pqe_pkg::IndexW-1:0]        vertex_count;
  logic signed [pqe_pkg::DeltaW-1:0] dx;
  logic signed [pqe_pkg::DeltaW-1:0] dy;
  logic [pqe_pkg::MagW-1:0]          ax;
  logic [pqe_pkg::MagW-1:0]          ay;
  logic [pqe_pkg::SqW-1:0]           sq;
  logic [pqe_pkg::RadW-1:0]          rad;
  logic [pqe_pkg::RootW-1:0]         root;
  logic [pqe_pkg::RadW+1:0]          rem;
  logic [CntW-1:0]                   cnt;
  logic [pqe_pkg::QuotW-1:0]         num;
  logic [pqe_pkg::DenW:0]            drem;
  logic [pqe_pkg::QuotW-1:0]         quo;
  logic [pqe_pkg::MagW-1:0]          qx;
  logic [pqe_pkg::MagW-1:0]          qy;
  logic                              mul_sel;

  // Restoring square root: two radicand bits a step.
  logic [pqe_pkg::RadW+1:0] rem_sh;
  logic [pqe_pkg::RadW+1:0] trial;
  assign rem_sh = {rem[pqe_pkg::RadW-1:0], rad[pqe_pkg::RadW-1 -: 2]};
  assign trial  = (pqe_pkg::RadW+2)'({root, 2'b01});

  // Restoring divider by 2L: one quotient bit a step.
  logic [pqe_pkg::DenW:0] den;
  logic [pqe_pkg::DenW:0] dsh;
  assign den = {1'b0, root, 1'b0};
  assign dsh = {drem[pqe_pkg::DenW-1:0], num[pqe_pkg::QuotW-1]};

  // Numerator 2*|d|*t*128 + L, one multiply shared for both axes.
  logic [pqe_pkg::MagW+pqe_pkg::ThickW-1:0] prod;
  assign prod = (mul_sel ? ay : ax) * line_thickness;
  logic [pqe_pkg::QuotW-1:0] num_new;
  assign num_new = pqe_pkg::QuotW'({prod, 8'b0}) + pqe_pkg::QuotW'(root);

  logic signed [pqe_pkg::CoordW+1:0] ox;
  logic signed [pqe_pkg::CoordW+1:0] oy;
  assign ox = dx[pqe_pkg::DeltaW-1] ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign oy = dy[pqe_pkg::DeltaW-1] ? -$signed({2'b00, qy}) : $signed({2'b00, qy});

  function automatic logic signed [pqe_pkg::CoordW+1:0] ext(
    input logic signed [pqe_pkg::CoordW-1:0] v
  );
    return {{2{v[pqe_pkg::CoordW-1]}}, v};
  endfunction

  // A finished quad waits in the result register, so the next job may start
  // while the consumer has not yet taken it.
  assign job_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      res_valid    <= 1'b0;
      vertex_count <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid && job_ready) begin
            if (job.clear) begin
              vertex_count <= '0;
            end else begin
              cur   <= job;
              dx    <= pqe_pkg::DeltaW'(job.ex) - pqe_pkg::DeltaW'(job.sx);
              dy    <= pqe_pkg::DeltaW'(job.ey) - pqe_pkg::DeltaW'(job.sy);
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          ax <= pqe_pkg::MagW'(dx[pqe_pkg::DeltaW-1] ? -dx : dx);
          ay <= pqe_pkg::MagW'(dy[pqe_pkg::DeltaW-1] ? -dy : dy);
          sq <= pqe_pkg::SqW'(dx * dx) + pqe_pkg::SqW'(dy * dy);
          state <= S_SQRT;
          cnt   <= '0;
          root  <= '0;
          rem   <= '0;
        end
        S_SQRT: begin
          if (cnt == '0) begin
            rad <= {sq, 16'b0};
            if (sq == '0) begin
              qx    <= '0;
              qy    <= '0;
              state <= S_OUT;
            end
            cnt <= CntW'(1);
          end else begin
            rad <= {rad[pqe_pkg::RadW-3:0], 2'b00};
            if (rem_sh >= trial) begin
              rem  <= rem_sh - trial;
              root <= {root[pqe_pkg::RootW-2:0], 1'b1};
            end else begin
              rem  <= rem_sh;
              root <= {root[pqe_pkg::RootW-2:0], 1'b0};
            end
            if (cnt == CntW'(pqe_pkg::RootW)) begin
              mul_sel <= 1'b0;
              state   <= S_MULX;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_MULX: begin
          num   <= num_new;
          drem  <= '0;
          cnt   <= '0;
          state <= mul_sel ? S_DIVY : S_DIVX;
        end
        S_DIVX, S_DIVY: begin
          num <= {num[pqe_pkg::QuotW-2:0], 1'b0};
          if (dsh >= den) begin
            drem <= dsh - den;
            quo  <= {quo[pqe_pkg::QuotW-2:0], 1'b1};
          end else begin
            drem <= dsh;
            quo  <= {quo[pqe_pkg::QuotW-2:0], 1'b0};
          end
          if (cnt == CntW'(pqe_pkg::QuotW - 1)) begin
            if (state == S_DIVX) begin
              qx      <= pqe_pkg::MagW'({quo[pqe_pkg::QuotW-2:0], dsh >= den});
              mul_sel <= 1'b1;
              state   <= S_MULX;
            end else begin
              qy    <= pqe_pkg::MagW'({quo[pqe_pkg::QuotW-2:0], dsh >= den});
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res.v0_x <= pqe_pkg::sat_coord(ext(cur.sx) + oy);
            res.v0_y <= pqe_pkg::sat_coord(ext(cur.sy) - ox);
            res.v1_x <= pqe_pkg::sat_coord(ext(cur.ex) + oy);
            res.v1_y <= pqe_pkg::sat_coord(ext(cur.ey) - ox);
            res.v2_x <= pqe_pkg::sat_coord(ext(cur.ex) - oy);
            res.v2_y <= pqe_pkg::sat_coord(ext(cur.ey) + ox);
            res.v3_x <= pqe_pkg::sat_coord(ext(cur.sx) - oy);
            res.v3_y <= pqe_pkg::sat_coord(ext(cur.sy) + ox);
            res.vertex_color <= line_color;
            res.base_index   <= vertex_count;
            res.last_of_run  <= cur.last;
            res_valid    <= 1'b1;
            vertex_count <= vertex_count + pqe_pkg::IndexW'(4);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/polyline_quad_expander.sv
// Polyline quad expander: turns each polyline segment into a thick quad.
// Each segment runs through a 29-step square root and two 42-step divisions;
// a zero-length segment skips them. The front end holds one segment job
// while the engine works, and a last point also yields the closing segment.
// Reset (rst, synchronous): clears the polyline state, the vertex counter
// and the queues; color returns to all ones and thickness to 1.0.
module polyline_quad_expander (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  pqe_pkg::in_req_t             in_data,
  output logic                         full,
  output logic                         empty,
  input  logic                         pop,
  output pqe_pkg::out_req_t            out_data,
  input  logic                         cfg_we,
  input  logic [pqe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pqe_pkg::ColorW-1:0]   cfg_data
);

  logic [pqe_pkg::ColorW-1:0] line_color;
  logic [pqe_pkg::ThickW-1:0] line_thickness;
  logic                       in_ready;
  logic                       job_valid;
  logic                       job_ready;
  pqe_pkg::seg_job_t          job;
  logic                       res_valid;

  // Configuration registers are written directly from the write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_color     <= '1;
      line_thickness <= pqe_pkg::ThickW'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pqe_pkg::RegColor: line_color     <= cfg_data;
        pqe_pkg::RegThick: line_thickness <= cfg_data[pqe_pkg::ThickW-1:0];
        default: ;
      endcase
    end
  end

  assign full  = !in_ready;
  assign empty = !res_valid;

  // The front end tracks the polyline and queues segment requests; the
  // engine computes the offset and holds one finished quad for the consumer.
  pqe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push),
    .in_req    (in_data),
    .in_ready  (in_ready),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  pqe_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .job_ready      (job_ready),
    .line_color     (line_color),
    .line_thickness (line_thickness),
    .res_valid      (res_valid),
    .res            (out_data),
    .res_ready      (pop)
  );

endmodule
